@@ rtl/b2c_pkg.sv @@
package b2c_pkg;

	localparam int NUM_CELLS       = 16;
	localparam int NUM_PLANE_CELLS = 7;
	localparam int MAX_WIDTH       = 4096;
	localparam int MAX_HEIGHT      = 4096;
	localparam int CFG_W           = 13;
	localparam int CNT_W           = 13;
	localparam int ROW_W           = 12;

	typedef enum logic [2:0] {
		MODE_1P     = 3'd0,
		MODE_2P     = 3'd1,
		MODE_4P     = 3'd2,
		MODE_8P     = 3'd3,
		MODE_RGB565 = 3'd4
	} plane_mode_t;

	typedef enum logic [1:0] {
		REG_PLANE_MODE   = 2'd0,
		REG_IMAGE_WIDTH  = 2'd1,
		REG_IMAGE_HEIGHT = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [7:0] idx;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       row_end;
		logic       frame_end;
	} pixel_t;

	typedef struct packed {
		logic                 load;
		logic [NUM_CELLS-1:0] vmask;
	} load_ctl_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

@@ rtl/b2c_channels.sv @@
interface b2c_word_if;
	logic        valid;
	logic        ready;
	logic [15:0] data_word;

	modport source (output valid, output data_word, input ready);
	modport sink (input valid, input data_word, output ready);
endinterface

interface b2c_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       row_end;
	logic       frame_end;

	modport source (output valid, output pixel_index, output red, output green,
		output blue, output row_end, output frame_end, input ready);
	modport sink (input valid, input pixel_index, input red, input green,
		input blue, input row_end, input frame_end, output ready);
endinterface

@@ rtl/b2c_pixel_cell.sv @@
module b2c_pixel_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  b2c_pkg::cell_ctl_t ctl,
	input  logic              load_valid,
	input  b2c_pkg::pixel_t   load_px,
	input  logic              next_valid,
	input  b2c_pkg::pixel_t   next_px,
	output logic              valid,
	output b2c_pkg::pixel_t   px
);

	logic            valid_q;
	b2c_pkg::pixel_t px_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load) begin
			valid_q <= load_valid;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end
	end

	// payload follows the same choice, no reset
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			px_q <= load_px;
		end else if (ctl.shift) begin
			px_q <= next_px;
		end
	end

	assign valid = valid_q;
	assign px    = px_q;

endmodule

@@ rtl/b2c_front.sv @@
module b2c_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [b2c_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              accept,
	input  logic [15:0]                       data_word,
	output b2c_pkg::load_ctl_t                ld,
	output b2c_pkg::pixel_t                   load_px [b2c_pkg::NUM_CELLS]
);

	localparam logic [b2c_pkg::CNT_W-1:0] WMAX = b2c_pkg::CNT_W'(b2c_pkg::MAX_WIDTH);
	localparam logic [b2c_pkg::CNT_W-1:0] HMAX = b2c_pkg::CNT_W'(b2c_pkg::MAX_HEIGHT);

	logic [2:0]               mode_q;
	logic [b2c_pkg::CFG_W-1:0] width_q;
	logic [b2c_pkg::CFG_W-1:0] height_q;
	logic [2:0]               pc_q;
	logic [b2c_pkg::CNT_W-1:0] col_q;
	logic [b2c_pkg::ROW_W-1:0] row_q;
	logic [15:0]              pw_q [b2c_pkg::NUM_PLANE_CELLS];

	logic [b2c_pkg::CNT_W-1:0] w_eff;
	logic [b2c_pkg::CNT_W-1:0] h_eff;
	logic [b2c_pkg::CNT_W-1:0] padded;
	logic [2:0]               last_pc;
	logic                     gather;
	logic                     produce;
	logic [4:0]               npix;
	logic [b2c_pkg::CNT_W-1:0] col_adv;
	logic [b2c_pkg::CNT_W:0]   row_inc;
	logic                     last_row;

	// effective sizes: zero acts as one, clamp at the maximum
	always_comb begin
		if (width_q == '0) begin
			w_eff = b2c_pkg::CNT_W'(1);
		end else if (width_q > WMAX) begin
			w_eff = WMAX;
		end else begin
			w_eff = width_q;
		end
		if (height_q == '0) begin
			h_eff = b2c_pkg::CNT_W'(1);
		end else if (height_q > HMAX) begin
			h_eff = HMAX;
		end else begin
			h_eff = height_q;
		end
		padded   = (w_eff + b2c_pkg::CNT_W'(15)) & ~b2c_pkg::CNT_W'(15);
		last_row = ({1'b0, row_q} == h_eff - b2c_pkg::CNT_W'(1));
		row_inc  = {2'b00, row_q} + (b2c_pkg::CNT_W + 1)'(1);
	end

	// word classification
	always_comb begin
		last_pc = 3'd0;
		gather  = 1'b0;
		produce = 1'b0;
		npix    = 5'd0;
		unique case (mode_q)
			b2c_pkg::MODE_1P: begin
				produce = 1'b1;
				npix    = 5'd16;
			end
			b2c_pkg::MODE_2P, b2c_pkg::MODE_4P, b2c_pkg::MODE_8P: begin
				unique case (mode_q)
					b2c_pkg::MODE_2P: last_pc = 3'd1;
					b2c_pkg::MODE_4P: last_pc = 3'd3;
					default:          last_pc = 3'd7;
				endcase
				gather  = (pc_q < last_pc);
				produce = !gather;
				npix    = gather ? 5'd0 : 5'd16;
			end
			b2c_pkg::MODE_RGB565: begin
				produce = 1'b1;
				npix    = 5'd1;
			end
			default: begin
				produce = 1'b0;
			end
		endcase
		col_adv = col_q + b2c_pkg::CNT_W'(npix);
	end

	// one pixel per output cell, leftmost pixel into the head cell
	always_comb begin
		logic [b2c_pkg::CNT_W-1:0] colj;
		logic                      re;
		for (int j = 0; j < b2c_pkg::NUM_CELLS; j++) begin
			colj = col_q + b2c_pkg::CNT_W'(j);
			re   = (colj == w_eff - b2c_pkg::CNT_W'(1));
			ld.vmask[j]          = (5'(j) < npix) && (colj < w_eff);
			load_px[j].row_end   = re;
			load_px[j].frame_end = re && last_row;
			load_px[j].idx       = '0;
			load_px[j].red       = '0;
			load_px[j].green     = '0;
			load_px[j].blue      = '0;
			unique case (mode_q)
				b2c_pkg::MODE_1P: begin
					load_px[j].idx[0] = data_word[15-j];
				end
				b2c_pkg::MODE_2P: begin
					load_px[j].idx[0] = pw_q[0][15-j];
					load_px[j].idx[1] = data_word[15-j];
				end
				b2c_pkg::MODE_4P: begin
					load_px[j].idx[0] = pw_q[2][15-j];
					load_px[j].idx[1] = pw_q[1][15-j];
					load_px[j].idx[2] = pw_q[0][15-j];
					load_px[j].idx[3] = data_word[15-j];
				end
				b2c_pkg::MODE_8P: begin
					for (int k = 0; k < b2c_pkg::NUM_PLANE_CELLS; k++) begin
						load_px[j].idx[k] = pw_q[b2c_pkg::NUM_PLANE_CELLS-1-k][15-j];
					end
					load_px[j].idx[7] = data_word[15-j];
				end
				b2c_pkg::MODE_RGB565: begin
					load_px[j].red   = {data_word[15:11], 3'b000};
					load_px[j].green = {data_word[10:5], 2'b00};
					load_px[j].blue  = {data_word[4:0], 3'b000};
				end
				default: begin
					load_px[j].idx = '0;
				end
			endcase
		end
		ld.load = accept;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= b2c_pkg::MODE_1P;
			width_q  <= b2c_pkg::CFG_W'(320);
			height_q <= b2c_pkg::CFG_W'(200);
		end else if (cfg_we) begin
			unique case (cfg_index)
				b2c_pkg::REG_PLANE_MODE:   mode_q   <= cfg_data[2:0];
				b2c_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				b2c_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// plane counter, column and row position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we && cfg_index == b2c_pkg::REG_PLANE_MODE) begin
			pc_q <= '0;
		end else if (accept) begin
			if (gather) begin
				pc_q <= pc_q + 3'd1;
			end else if (produce) begin
				pc_q <= '0;
				if (col_adv >= padded) begin
					col_q <= '0;
					row_q <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[b2c_pkg::ROW_W-1:0];
				end else begin
					col_q <= col_adv;
				end
			end
		end
	end

	// chain of plane word cells, newest word at the front
	always_ff @(posedge clk) begin
		if (accept && gather) begin
			pw_q[0] <= data_word;
			for (int k = 1; k < b2c_pkg::NUM_PLANE_CELLS; k++) begin
				pw_q[k] <= pw_q[k-1];
			end
		end
	end

endmodule

@@ rtl/bitplane_to_chunky_pixels.sv @@
// channel   dir  payload                                        handshake
// words     in   data_word[15:0]                                valid/ready
// pixels    out  pixel_index, red, green, blue, row_end,        valid/ready
//                frame_end
// cfg       in   cfg_index[1:0], cfg_data[12:0]                 cfg_we, no wait
//
// a word is converted in the cycle it is taken and loaded in parallel into a
// chain of 16 pixel cells; the head cell drives the output and the chain
// shifts one cell each cycle a pixel is taken, so a word yields up to 16
// pixels at one pixel per cycle while the output is not stalled; an rgb565
// word yields at most one pixel and a plane word being gathered none. the
// next word is taken while the last pixel of the previous one is taken, so
// a 1-plane stream runs without gaps; a stalled output holds the chain and words.
// asynchronous reset empties the chain and clears the counters

module bitplane_to_chunky_pixels (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [b2c_pkg::CFG_W-1:0]  cfg_data,
	b2c_word_if.sink                   words,
	b2c_pix_if.source                  pixels
);

	localparam int N = b2c_pkg::NUM_CELLS;

	b2c_pkg::load_ctl_t ld;
	b2c_pkg::pixel_t    load_px [N];
	b2c_pkg::pixel_t    cell_px [N];
	logic [N-1:0]       cell_v;
	b2c_pkg::cell_ctl_t ctl;
	logic               in_fire;
	logic               out_fire;

	// take a word once at most the head pixel remains and it leaves now
	assign words.ready = !cell_v[1] && (!cell_v[0] || pixels.ready);
	assign in_fire     = words.valid && words.ready;
	assign out_fire    = pixels.valid && pixels.ready;

	b2c_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (in_fire),
		.data_word (words.data_word),
		.ld        (ld),
		.load_px   (load_px)
	);

	// the whole chain loads or shifts together
	assign ctl.load  = ld.load;
	assign ctl.shift = out_fire;

	for (genvar j = 0; j < N; j++) begin : g_cell
		logic            nv;
		b2c_pkg::pixel_t np;
		if (j == N - 1) begin : g_tail
			assign nv = 1'b0;
			assign np = cell_px[j];
		end else begin : g_mid
			assign nv = cell_v[j+1];
			assign np = cell_px[j+1];
		end
		b2c_pixel_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.load_valid (ld.vmask[j]),
			.load_px    (load_px[j]),
			.next_valid (nv),
			.next_px    (np),
			.valid      (cell_v[j]),
			.px         (cell_px[j])
		);
	end

	// head cell is the output register
	assign pixels.valid       = cell_v[0];
	assign pixels.pixel_index = cell_px[0].idx;
	assign pixels.red         = cell_px[0].red;
	assign pixels.green       = cell_px[0].green;
	assign pixels.blue        = cell_px[0].blue;
	assign pixels.row_end     = cell_px[0].row_end;
	assign pixels.frame_end   = cell_px[0].frame_end;

	// pending pixels always sit at the head of the chain
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_v[N-1:1] & ~cell_v[N-2:0]) == '0)
		else $error("gap in pixel chain");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		ld.load |=> (cell_v == $past(ld.vmask)))
		else $error("chain does not hold the loaded pixels");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && !ld.load) |=> ($countones(cell_v) == $countones($past(cell_v)) - 1))
		else $error("taken pixel not removed exactly once");

	a_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(pixels.valid && pixels.frame_end) |-> pixels.row_end)
		else $error("frame end without row end");

endmodule
